// File: rtl/core/rmps_pkg.sv
// Shared types and codes of the rate-monotonic scheduler core.
package rmps_pkg;

    localparam int OPCODE_W  = 2;
    localparam int ID_W      = 8;
    localparam int RANK_W    = 8;
    localparam int SERVICE_W = 16;
    localparam int TIME_W    = 32;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PERIODIC  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_APERIODIC = 2'd2;

    // Result kinds.
    localparam logic EV_DONE = 1'b0;
    localparam logic EV_DROP = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [ID_W-1:0]      task_id;
        logic [RANK_W-1:0]    period_rank;
        logic [SERVICE_W-1:0] service_time;
    } in_item_t;

    typedef struct packed {
        logic                 event_kind;
        logic [ID_W-1:0]      done_id;
        logic                 done_periodic;
        logic [TIME_W-1:0]    event_time;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_PERIODIC,
        KIND_APERIODIC
    } item_kind_t;

    // Classified request handed from the front end to the engine.
    typedef struct packed {
        item_kind_t           kind;
        logic [ID_W-1:0]      task_id;
        logic [RANK_W-1:0]    period_rank;
        logic [SERVICE_W-1:0] service_time;
    } work_item_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } sq_cmd_t;

    typedef struct packed {
        logic busy;
        logic empty;
        logic full;
    } sq_stat_t;

endpackage

// File: rtl/core/rmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/rmps_sorted_queue.sv
// Rank-sorted circular queue in RAM: pop at the head, insert by shifting from the tail.
module rmps_sorted_queue #(
    parameter int DEPTH    = 16,
    parameter int EW       = 32,
    parameter int RANK_LSB = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rmps_pkg::sq_cmd_t cmd,
    input  logic [EW-1:0]     wentry,
    output rmps_pkg::sq_stat_t stat,
    output logic [EW-1:0]     rentry
);
    import rmps_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = AW + 1;

    typedef enum logic [1:0] {SQ_IDLE, SQ_SCAN, SQ_PUT} sq_state_t;

    sq_state_t       state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [EW-1:0]   ent_reg, ent_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic [PW-1:0]   tail_off;

    // Physical slot of a logical position counted from the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [PW-1:0] off);
        logic [PW-1:0] s;
        s = PW'(h) + off;
        if (s >= PW'(DEPTH)) begin
            s = s - PW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign tail_off = PW'(count_reg) - PW'(1);

    // Insert scans from the tail one entry a cycle; larger ranks move up one slot.
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ent_next   = ent_reg;
        we         = 1'b0;
        waddr      = head_reg;
        wdata      = ent_reg;
        raddr      = head_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (cmd.insert) begin
                    ent_next   = wentry;
                    count_next = count_reg + CW'(1);
                    if (count_reg == '0) begin
                        we    = 1'b1;
                        waddr = head_reg;
                        wdata = wentry;
                    end else begin
                        raddr      = phys(head_reg, tail_off);
                        idx_next   = tail_off[AW-1:0];
                        state_next = SQ_SCAN;
                    end
                end else if (cmd.pop) begin
                    head_next  = phys(head_reg, PW'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            SQ_SCAN: begin
                we    = 1'b1;
                waddr = phys(head_reg, PW'(idx_reg) + PW'(1));
                if (rdata[RANK_LSB +: RANK_W] > ent_reg[RANK_LSB +: RANK_W]) begin
                    wdata = rdata;
                    if (idx_reg == '0) begin
                        state_next = SQ_PUT;
                    end else begin
                        raddr    = phys(head_reg, PW'(idx_reg) - PW'(1));
                        idx_next = idx_reg - AW'(1);
                    end
                end else begin
                    wdata      = ent_reg;
                    state_next = SQ_IDLE;
                end
            end
            SQ_PUT: begin
                we         = 1'b1;
                waddr      = head_reg;
                wdata      = ent_reg;
                state_next = SQ_IDLE;
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        idx_reg <= idx_next;
        ent_reg <= ent_next;
    end

    rmps_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.busy  = (state_reg != SQ_IDLE);
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign rentry     = rdata;

endmodule

// File: rtl/core/rmps_front.sv
// Front end: accepts input requests, classifies them and holds them in a two-entry queue.
module rmps_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rmps_pkg::in_item_t   s_data,
    output logic                 w_valid,
    input  logic                 w_ready,
    output rmps_pkg::work_item_t w_item
);
    import rmps_pkg::*;

    work_item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       accept, keep, take;
    work_item_t cls;

    assign s_ready = (fill_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign w_valid = (fill_reg != 2'd0);
    assign w_item  = slot_reg[rd_ptr_reg];
    assign take    = w_valid && w_ready;

    // Unused opcodes change nothing and are not queued.
    always_comb begin
        cls.task_id      = s_data.task_id;
        cls.period_rank  = s_data.period_rank;
        cls.service_time = s_data.service_time;
        cls.kind         = KIND_TICK;
        keep             = accept;
        case (s_data.opcode)
            OP_TICK:      cls.kind = KIND_TICK;
            OP_PERIODIC:  cls.kind = KIND_PERIODIC;
            OP_APERIODIC: cls.kind = KIND_APERIODIC;
            default:      keep     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (keep) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(keep) - 2'(take);
        end
    end

    always_ff @(posedge aclk) begin
        if (keep) begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: rtl/core/rmps_engine.sv
// Back end: server state, preemption decisions, queue commands and the result register.
module rmps_engine #(
    parameter int IDW = 8,
    parameter int SVW = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rmps_pkg::TIME_W-1:0]            cfg_data,
    input  logic                                   w_valid,
    output logic                                   w_ready,
    input  rmps_pkg::work_item_t                   w_item,
    output rmps_pkg::sq_cmd_t                      left_cmd,
    output rmps_pkg::sq_cmd_t                      per_cmd,
    output rmps_pkg::sq_cmd_t                      fifo_cmd,
    output logic [IDW+rmps_pkg::RANK_W+SVW-1:0]    ins_entry,
    input  rmps_pkg::sq_stat_t                     left_stat,
    input  rmps_pkg::sq_stat_t                     per_stat,
    input  rmps_pkg::sq_stat_t                     fifo_stat,
    input  logic [IDW+rmps_pkg::RANK_W+SVW-1:0]    left_rentry,
    input  logic [IDW+rmps_pkg::RANK_W+SVW-1:0]    per_rentry,
    input  logic [IDW+rmps_pkg::RANK_W+SVW-1:0]    fifo_rentry,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rmps_pkg::out_item_t                    m_data
);
    import rmps_pkg::*;

    localparam int EW = IDW + RANK_W + SVW;

    typedef enum logic {ENG_IDLE, ENG_POP} eng_state_t;
    typedef enum logic [1:0] {SRC_LEFT, SRC_PER, SRC_FIFO} pop_src_t;

    eng_state_t        state_reg, state_next;
    pop_src_t          src_reg, src_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [TIME_W-1:0] end_reg, end_next;
    logic              busy_reg, busy_next;
    logic              run_per_reg, run_per_next;
    logic [IDW-1:0]    run_id_reg, run_id_next;
    logic [RANK_W-1:0] run_rank_reg, run_rank_next;
    logic [SVW-1:0]    run_rem_reg, run_rem_next;
    logic              ap_valid_reg, ap_valid_next;
    logic [EW-1:0]     ap_entry_reg, ap_entry_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [IDW-1:0]    t_id;
    logic [RANK_W-1:0] t_rank;
    logic [SVW-1:0]    t_rem;
    logic [EW-1:0]     new_entry, saved_entry, start_entry, pop_entry;
    logic [TIME_W-1:0] time_inc;
    logic              do_start, start_per, do_next, queues_busy;

    assign t_id        = w_item.task_id[IDW-1:0];
    assign t_rank      = w_item.period_rank;
    assign t_rem       = w_item.service_time[SVW-1:0];
    assign new_entry   = {t_id, t_rank, t_rem};
    assign saved_entry = {run_id_reg, run_rank_reg, run_rem_reg};
    assign time_inc    = time_reg + TIME_W'(1);
    assign queues_busy = left_stat.busy || per_stat.busy || fifo_stat.busy;
    assign cfg_ready   = 1'b1;

    always_comb begin
        case (src_reg)
            SRC_LEFT: pop_entry = left_rentry;
            SRC_PER:  pop_entry = per_rentry;
            default:  pop_entry = fifo_rentry;
        endcase
    end

    // One request is decided per cycle unless a result waits or a queue is busy; pops add ENG_POP.
    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        time_next     = time_reg;
        end_next      = cfg_valid ? cfg_data : end_reg;
        busy_next     = busy_reg;
        run_per_next  = run_per_reg;
        run_id_next   = run_id_reg;
        run_rank_next = run_rank_reg;
        run_rem_next  = run_rem_reg;
        ap_valid_next = ap_valid_reg;
        ap_entry_next = ap_entry_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        left_cmd      = '0;
        per_cmd       = '0;
        fifo_cmd      = '0;
        ins_entry     = new_entry;
        w_ready       = 1'b0;
        do_start      = 1'b0;
        start_per     = 1'b0;
        start_entry   = new_entry;
        do_next       = 1'b0;

        case (state_reg)
            ENG_IDLE: begin
                if (w_valid && !m_valid_reg && !queues_busy) begin
                    w_ready = 1'b1;
                    if (time_reg < end_reg) begin
                        case (w_item.kind)
                            KIND_TICK: begin
                                time_next = time_inc;
                                if (time_inc < end_reg && busy_reg) begin
                                    if (run_rem_reg > SVW'(1)) begin
                                        run_rem_next = run_rem_reg - SVW'(1);
                                    end else begin
                                        m_valid_next             = 1'b1;
                                        m_data_next.event_kind   = EV_DONE;
                                        m_data_next.done_id      = ID_W'(run_id_reg);
                                        m_data_next.done_periodic = run_per_reg;
                                        m_data_next.event_time   = time_inc;
                                        do_next                  = 1'b1;
                                    end
                                end
                            end
                            KIND_APERIODIC: begin
                                if (!busy_reg) begin
                                    do_start = 1'b1;
                                end else if (fifo_stat.full) begin
                                    m_valid_next              = 1'b1;
                                    m_data_next.event_kind    = EV_DROP;
                                    m_data_next.done_id       = ID_W'(t_id);
                                    m_data_next.done_periodic = 1'b0;
                                    m_data_next.event_time    = time_reg;
                                end else begin
                                    fifo_cmd.insert = 1'b1;
                                    ins_entry       = {t_id, RANK_W'(0), t_rem};
                                end
                            end
                            KIND_PERIODIC: begin
                                start_per = 1'b1;
                                if (!busy_reg) begin
                                    do_start = 1'b1;
                                end else if (run_per_reg) begin
                                    if (t_rank < run_rank_reg && !left_stat.full) begin
                                        left_cmd.insert = 1'b1;
                                        ins_entry       = saved_entry;
                                        do_start        = 1'b1;
                                    end else if (!per_stat.full) begin
                                        per_cmd.insert = 1'b1;
                                    end else begin
                                        m_valid_next              = 1'b1;
                                        m_data_next.event_kind    = EV_DROP;
                                        m_data_next.done_id       = ID_W'(t_id);
                                        m_data_next.done_periodic = 1'b1;
                                        m_data_next.event_time    = time_reg;
                                    end
                                end else if (ap_valid_reg) begin
                                    m_valid_next              = 1'b1;
                                    m_data_next.event_kind    = EV_DROP;
                                    m_data_next.done_id       = ID_W'(t_id);
                                    m_data_next.done_periodic = 1'b1;
                                    m_data_next.event_time    = time_reg;
                                end else begin
                                    ap_valid_next = 1'b1;
                                    ap_entry_next = saved_entry;
                                    do_start      = 1'b1;
                                end
                            end
                            default: begin
                                time_next = time_reg;
                            end
                        endcase
                    end
                end
            end
            ENG_POP: begin
                do_start    = 1'b1;
                start_entry = pop_entry;
                start_per   = (src_reg != SRC_FIFO);
                state_next  = ENG_IDLE;
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase

        // Next task after a completion, in priority order of the waiting stores.
        if (do_next) begin
            if (!left_stat.empty) begin
                left_cmd.pop = 1'b1;
                src_next     = SRC_LEFT;
                state_next   = ENG_POP;
            end else if (!per_stat.empty) begin
                per_cmd.pop = 1'b1;
                src_next    = SRC_PER;
                state_next  = ENG_POP;
            end else if (ap_valid_reg) begin
                ap_valid_next = 1'b0;
                do_start      = 1'b1;
                start_entry   = ap_entry_reg;
                start_per     = 1'b0;
            end else if (!fifo_stat.empty) begin
                fifo_cmd.pop = 1'b1;
                src_next     = SRC_FIFO;
                state_next   = ENG_POP;
            end else begin
                busy_next    = 1'b0;
                run_rem_next = '0;
            end
        end

        if (do_start) begin
            busy_next     = 1'b1;
            run_per_next  = start_per;
            run_id_next   = start_entry[RANK_W+SVW +: IDW];
            run_rank_next = start_entry[SVW +: RANK_W];
            run_rem_next  = start_entry[SVW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ENG_IDLE;
            time_reg     <= '0;
            end_reg      <= '1;
            busy_reg     <= 1'b0;
            ap_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            run_rem_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            time_reg     <= time_next;
            end_reg      <= end_next;
            busy_reg     <= busy_next;
            ap_valid_reg <= ap_valid_next;
            m_valid_reg  <= m_valid_next;
            run_rem_reg  <= run_rem_next;
        end
        src_reg      <= src_next;
        run_per_reg  <= run_per_next;
        run_id_reg   <= run_id_next;
        run_rank_reg <= run_rank_next;
        ap_entry_reg <= ap_entry_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/rate_monotonic_preemptive_scheduler_core.sv
// Top level of the preemptive rate-monotonic scheduler with background aperiodic service.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    in_item_t (opcode, task_id, period_rank, service_time)
//   m_       out        m_valid/m_ready    out_item_t (event_kind, done_id, done_periodic, time)
//   cfg_     in         cfg_valid/cfg_ready end_time write data
//
// A tick or an arrival that needs no queue is decided in ENG_IDLE; a completion that starts a
// queued task also passes ENG_POP for the RAM read of the queue head. A sorted insert shifts
// entries in the one-entry-per-cycle tail scan in the queue RAM.
// Reset is synchronous; queues come up empty with no clearing pass.
// The front queue keeps taking requests into its two slots while a result waits in the output register.
module rate_monotonic_preemptive_scheduler_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ID_BITS      = 8,
    parameter int SERVICE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rmps_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rmps_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmps_pkg::TIME_W-1:0]   cfg_data
);
    import rmps_pkg::*;

    localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int SVW = (SERVICE_BITS < SERVICE_W) ? SERVICE_BITS : SERVICE_W;
    localparam int EW  = IDW + RANK_W + SVW;

    logic          work_valid, work_ready;
    work_item_t    work_item;
    sq_cmd_t       left_cmd, per_cmd, fifo_cmd;
    sq_stat_t      left_stat, per_stat, fifo_stat;
    logic [EW-1:0] ins_entry, left_rentry, per_rentry, fifo_rentry;

    rmps_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .w_valid (work_valid),
        .w_ready (work_ready),
        .w_item  (work_item)
    );

    // Preempted periodic tasks.
    rmps_sorted_queue #(.DEPTH(QUEUE_DEPTH), .EW(EW), .RANK_LSB(SVW)) u_left_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (left_cmd),
        .wentry  (ins_entry),
        .stat    (left_stat),
        .rentry  (left_rentry)
    );

    // Waiting periodic tasks.
    rmps_sorted_queue #(.DEPTH(QUEUE_DEPTH), .EW(EW), .RANK_LSB(SVW)) u_per_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (per_cmd),
        .wentry  (ins_entry),
        .stat    (per_stat),
        .rentry  (per_rentry)
    );

    // Aperiodic tasks; all ranks are equal, so the sorted queue acts as a FIFO.
    rmps_sorted_queue #(.DEPTH(QUEUE_DEPTH), .EW(EW), .RANK_LSB(SVW)) u_fifo_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (fifo_cmd),
        .wentry  (ins_entry),
        .stat    (fifo_stat),
        .rentry  (fifo_rentry)
    );

    rmps_engine #(.IDW(IDW), .SVW(SVW)) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .w_valid     (work_valid),
        .w_ready     (work_ready),
        .w_item      (work_item),
        .left_cmd    (left_cmd),
        .per_cmd     (per_cmd),
        .fifo_cmd    (fifo_cmd),
        .ins_entry   (ins_entry),
        .left_stat   (left_stat),
        .per_stat    (per_stat),
        .fifo_stat   (fifo_stat),
        .left_rentry (left_rentry),
        .per_rentry  (per_rentry),
        .fifo_rentry (fifo_rentry),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef NO_ASSERTIONS
    // The engine only takes a request when the result register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work_valid && work_ready) |-> !m_valid)
        else $error("engine took a request while a result was pending");

    // No request is decided while a queue insert is still shifting entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work_valid && work_ready) |-> !(left_stat.busy || per_stat.busy || fifo_stat.busy))
        else $error("engine took a request during a queue insert");

    // Inserts go only to queues with room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (left_cmd.insert || per_cmd.insert || fifo_cmd.insert) |->
        !((left_cmd.insert && left_stat.full) || (per_cmd.insert && per_stat.full) ||
          (fifo_cmd.insert && fifo_stat.full)))
        else $error("insert issued to a full queue");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the rate-monotonic preemptive scheduler core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmps_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 3000;
    // Room for a sorted insert in the engine plus one for each of the two front-queue slots.
    localparam int DRAIN_WAIT = 4 * DEPTH + 8;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic [ID_W-1:0]      id;
        logic [RANK_W-1:0]    rank;
        logic [SERVICE_W-1:0] rem;
    } job_t;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t result;
    } step_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [TIME_W-1:0] cfg_data;

    // Scheduler state as this testbench tracks it.
    logic [TIME_W-1:0] sched_end;
    logic [TIME_W-1:0] sched_now;
    bit                srv_busy;
    job_t              run_job;
    bit                run_periodic;
    logic [SERVICE_W-1:0] run_left;
    job_t              wait_periodic[$];
    job_t              wait_preempted[$];
    job_t              wait_aperiodic[$];
    job_t              parked_aperiodic;
    bit                parked_valid;

    out_item_t events_due[$];
    step_row_t directed_rows[$];
    bit        typed_next;
    out_item_t typed_value;
    int        errors;
    int        sent;
    int        completions;
    int        drops;
    int        stall_cycles;
    bit        calm;

    rate_monotonic_preemptive_scheduler_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 12 ns period.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Position behind every waiting job of the same or smaller rank.
    function automatic int rank_slot(job_t q[$], logic [RANK_W-1:0] rank);
        int pos;
        pos = 0;
        while (pos < q.size() && q[pos].rank <= rank)
            pos++;
        return pos;
    endfunction

    function automatic void launch(job_t j, bit periodic);
        srv_busy     = 1'b1;
        run_job      = j;
        run_periodic = periodic;
        run_left     = j.rem;
    endfunction

    function automatic job_t running_snapshot();
        job_t j;
        j     = run_job;
        j.rem = run_left;
        return j;
    endfunction

    // Pick the next job once the server frees up.
    function automatic void dispatch_next();
        if (wait_preempted.size() > 0) begin
            launch(wait_preempted.pop_front(), 1'b1);
        end else if (wait_periodic.size() > 0) begin
            launch(wait_periodic.pop_front(), 1'b1);
        end else if (parked_valid) begin
            parked_valid = 1'b0;
            launch(parked_aperiodic, 1'b0);
        end else if (wait_aperiodic.size() > 0) begin
            launch(wait_aperiodic.pop_front(), 1'b0);
        end else begin
            srv_busy = 1'b0;
            run_left = '0;
        end
    endfunction

    // Advance the scheduler by one request and report the event it raises.
    function automatic bit schedule_step(in_item_t req, output out_item_t ev);
        job_t j;
        ev = '0;
        if (sched_now >= sched_end)
            return 1'b0;
        j = '{req.task_id, req.period_rank, req.service_time};
        if (req.opcode == OP_TICK) begin
            sched_now++;
            if (sched_now >= sched_end || !srv_busy)
                return 1'b0;
            if (run_left > 1) begin
                run_left--;
                return 1'b0;
            end
            ev = '{EV_DONE, run_job.id, run_periodic, sched_now};
            dispatch_next();
            return 1'b1;
        end
        if (req.opcode == OP_UNUSED)
            return 1'b0;
        if (!srv_busy) begin
            launch(j, req.opcode == OP_PERIODIC);
            return 1'b0;
        end
        if (req.opcode == OP_APERIODIC) begin
            if (wait_aperiodic.size() >= DEPTH) begin
                ev = '{EV_DROP, j.id, 1'b0, sched_now};
                return 1'b1;
            end
            wait_aperiodic.push_back(j);
            return 1'b0;
        end
        if (run_periodic) begin
            if (j.rank < run_job.rank && wait_preempted.size() < DEPTH) begin
                wait_preempted.insert(rank_slot(wait_preempted, run_job.rank),
                                      running_snapshot());
                launch(j, 1'b1);
                return 1'b0;
            end
            if (wait_periodic.size() >= DEPTH) begin
                ev = '{EV_DROP, j.id, 1'b1, sched_now};
                return 1'b1;
            end
            wait_periodic.insert(rank_slot(wait_periodic, j.rank), j);
            return 1'b0;
        end
        // A periodic arrival displaces a running aperiodic job, unless one is already parked: then it is dropped.
        if (parked_valid) begin
            ev = '{EV_DROP, j.id, 1'b1, sched_now};
            return 1'b1;
        end
        parked_aperiodic = running_snapshot();
        parked_valid     = 1'b1;
        launch(j, 1'b1);
        return 1'b0;
    endfunction

    // Track accepted requests and check every event the core returns.
    always @(posedge aclk) begin
        out_item_t ev;
        out_item_t due;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sched_end = cfg_data;
            if (s_valid && s_ready) begin
                if (schedule_step(s_data, ev))
                    events_due.push_back(typed_next ? typed_value : ev);
            end
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    $display("%0t: unexpected event, actual %p", $time, m_data);
                    errors++;
                end else begin
                    due = events_due.pop_front();
                    if (m_data.event_kind == EV_DONE)
                        completions++;
                    else
                        drops++;
                    if (m_data.event_kind !== due.event_kind) begin
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, due.event_kind, m_data.event_kind);
                        errors++;
                    end
                    if (m_data.done_id !== due.done_id) begin
                        $display("%0t: done_id expected %0h actual %0h",
                                 $time, due.done_id, m_data.done_id);
                        errors++;
                    end
                    if (m_data.done_periodic !== due.done_periodic) begin
                        $display("%0t: done_periodic expected %0d actual %0d",
                                 $time, due.done_periodic, m_data.done_periodic);
                        errors++;
                    end
                    if (m_data.event_time !== due.event_time) begin
                        $display("%0t: event_time expected %0d actual %0d",
                                 $time, due.event_time, m_data.event_time);
                        errors++;
                    end
                end
            end
        end
    end

    // Abort when no channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Result-side back-pressure.
    always @(negedge aclk) begin
        m_ready = calm || ($urandom_range(99) >= 14);
    end

    // Send one request, idling at random before it.
    task automatic send_request(in_item_t req, bit typed, out_item_t result);
        while (!calm && $urandom_range(99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data      = req;
        typed_next  = typed;
        typed_value = result;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        s_valid    = 1'b0;
        typed_next = 1'b0;
    endtask

    // Write end_time once every pending event has come back.
    task automatic write_end_time(logic [TIME_W-1:0] value);
        while (events_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic in_item_t make_req(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                                          logic [RANK_W-1:0] rank,
                                          logic [SERVICE_W-1:0] svc);
        in_item_t r;
        r.opcode       = op;
        r.task_id      = id;
        r.period_rank  = rank;
        r.service_time = svc;
        return r;
    endfunction

    function automatic void add_row(in_item_t req);
        directed_rows.push_back('{req, 1'b0, '0});
    endfunction

    // One random stretch: a burst of arrivals, which may open with an unused opcode, or a run of ticks.
    task automatic random_round(bit wide_service);
        int n;
        int mode;
        logic [RANK_W-1:0] rank;
        logic [SERVICE_W-1:0] svc;
        logic [OPCODE_W-1:0] op;
        mode = $urandom_range(9);
        n    = $urandom_range(1, 20);
        rank = RANK_W'($urandom_range(255, 120));
        for (int k = 0; k < n; k++) begin
            if (mode < 4) begin
                op = OP_TICK;
            end else if (mode == 9 && k == 0) begin
                op = OP_UNUSED;
            end else begin
                op = ($urandom_range(2) == 0) ? OP_APERIODIC : OP_PERIODIC;
            end
            // Falling ranks stack up preemptions; otherwise ranks cluster for ties.
            if (mode >= 7) begin
                rank = rank - RANK_W'($urandom_range(7, 1));
            end else if ($urandom_range(9) == 0) begin
                rank = RANK_W'($urandom());
            end else begin
                rank = RANK_W'($urandom_range(15));
            end
            svc = wide_service ? SERVICE_W'($urandom()) : SERVICE_W'($urandom_range(6));
            send_request(make_req(op, ID_W'($urandom()), rank, svc), 1'b0, '0);
            sent++;
        end
    endtask

    // Directed requests first, then random phases under several end times.
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        typed_next  = 1'b0;
        typed_value = '0;
        errors = 0;
        sent   = 0;
        completions = 0;
        drops  = 0;
        calm   = 1'b0;
        sched_end = TIME_MAX;
        sched_now = '0;
        srv_busy  = 1'b0;
        run_job   = '{default: '0};
        run_periodic = 1'b0;
        run_left  = '0;
        parked_aperiodic = '{default: '0};
        parked_valid = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Idle tick, then a zero-service job that finishes at time 2.
        add_row(make_req(OP_TICK, 8'h00, 8'h00, 16'h0000));
        add_row(make_req(OP_PERIODIC, 8'hFF, 8'hFF, 16'h0000));
        directed_rows.push_back('{make_req(OP_TICK, 8'h00, 8'h00, 16'h0000), 1'b1,
                                  '{EV_DONE, 8'hFF, 1'b1, 32'd2}});
        // Aperiodic preempted by periodic, a rank tie, an unused opcode.
        add_row(make_req(OP_APERIODIC, 8'h00, 8'h00, 16'h0001));
        add_row(make_req(OP_PERIODIC, 8'h11, 8'h00, 16'h0002));
        add_row(make_req(OP_PERIODIC, 8'h22, 8'h00, 16'h0001));
        add_row(make_req(OP_APERIODIC, 8'h33, 8'hFF, 16'h0003));
        add_row(make_req(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF));
        for (int k = 0; k < 8; k++)
            add_row(make_req(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF));
        // Overfill the aperiodic FIFO behind a running periodic job.
        add_row(make_req(OP_PERIODIC, 8'h40, 8'h0A, 16'h0004));
        for (int k = 0; k < DEPTH + 1; k++)
            add_row(make_req(OP_APERIODIC, 8'(8'h50 + k), 8'h00, 16'h0001));
        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].result);

        // Random work that runs into a near end time.
        write_end_time(sched_now + TIME_W'(300));
        while (sent < 450)
            random_round(1'b0);
        // Zero end time: everything is ignored.
        write_end_time('0);
        for (int k = 0; k < 20; k++)
            send_request(make_req(OP_TICK, ID_W'($urandom()), RANK_W'($urandom()),
                                  SERVICE_W'($urandom())), 1'b0, '0);
        // End one tick away, so a completion due there is not reported.
        write_end_time(sched_now + TIME_W'(1));
        for (int k = 0; k < 4; k++)
            send_request(make_req(OP_TICK, 8'h00, 8'h00, 16'h0001), 1'b0, '0);
        write_end_time(TIME_MAX);
        while (sent < 1400) begin
            calm = (sent >= 700 && sent < 1000);
            random_round(1'b0);
        end
        calm = 1'b0;
        // Wide service times last, where they cannot block the run.
        for (int k = 0; k < 3; k++)
            random_round(1'b1);

        while (events_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        $display("Sent %0d scheduler requests over four end-time settings;", sent);
        $display("checked %0d completions and %0d dropped arrivals.", completions, drops);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: rate_monotonic_preemptive_scheduler_core.f
rtl/core/rmps_pkg.sv
rtl/core/rmps_ram.sv
rtl/core/rmps_sorted_queue.sv
rtl/core/rmps_front.sv
rtl/core/rmps_engine.sv
rtl/core/rate_monotonic_preemptive_scheduler_core.sv
tb/sv/testbench.sv
